/* design/cst_pkg.sv */
// Shared types and constants for the command slot tracker.
// Used by every module of the block; depends on nothing.
package cst_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int COUNT_W   = 6;
    localparam int TAG_W     = 16;
    localparam int ADDR_W    = 3;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] REG_SLOT_COUNT = 3'd0;

    typedef enum logic [1:0] {
        KIND_GRANT  = 2'd0,
        KIND_REFUSE = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             op;
        logic [TAG_W-1:0] request_tag;
        logic [31:0]      ci_vector;
        logic             d2h_seen;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  tag_out;
        logic [31:0]       issue_bit;
        logic              last;
    } result_t;

    // Answer of the shared lowest-set-bit unit
    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    index;
        logic                 more;
        logic [MAX_SLOTS-1:0] rest;
    } find_t;

endpackage

/* design/cst_find_first.sv */
// Shared lowest-set-bit unit: slot search for issue and completion walk.
// Depends on cst_pkg.
module cst_find_first (
    input  logic [cst_pkg::MAX_SLOTS-1:0] vec,
    output cst_pkg::find_t                res
);

    logic [cst_pkg::SLOT_W-1:0]    idx;
    logic [cst_pkg::MAX_SLOTS-1:0] rest;

    always_comb
    begin
        idx = '0;
        for (int i = cst_pkg::MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = cst_pkg::SLOT_W'(i);
            end
        end
    end

    // drop the lowest set bit
    assign rest = vec & (vec - cst_pkg::MAX_SLOTS'(1));

    assign res.found = |vec;
    assign res.index = idx;
    assign res.more  = |rest;
    assign res.rest  = rest;

endmodule

/* design/cst_tag_store.sv */
// Per-slot request tag memory, one write and one registered read port.
// Depends on cst_pkg.
module cst_tag_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [cst_pkg::SLOT_W-1:0]  wr_addr,
    input  logic [cst_pkg::TAG_W-1:0]   wr_data,
    input  logic [cst_pkg::SLOT_W-1:0]  rd_addr,
    output logic [cst_pkg::TAG_W-1:0]   rd_data
);

    logic [cst_pkg::TAG_W-1:0] mem [cst_pkg::MAX_SLOTS];
    logic [cst_pkg::TAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/command_slot_tracker.sv */
// Command slot tracker: top level with slot maps, sequencer and APB register.
// Depends on cst_pkg, cst_find_first and cst_tag_store.
//
// An issue command (op 0) keeps busy high for one cycle after start is taken,
// and the grant or refusal word is strobed by result_valid in the cycle after
// that, while busy is already low. A completion command (op 1) passes through
// a scan and an emit state for each freed slot: one lowest-set-bit unit walks
// the freed slots one at a time, and each word waits on the registered tag
// memory read. Words come out in ascending slot order, the final one with last
// set; a completion that frees nothing gives no word. result_valid lasts one
// cycle and cannot be stalled. slot_count sits at byte address 0 and must be
// written only while idle.
module command_slot_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cst_pkg::cmd_t                cmd,
    output logic                         result_valid,
    output cst_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cst_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int NS = cst_pkg::MAX_SLOTS;
    localparam int SW = cst_pkg::SLOT_W;
    localparam int CW = cst_pkg::COUNT_W;

    cst_pkg::state_t         state_reg, state_next;
    logic [CW-1:0]           slot_count_reg;
    logic [NS-1:0]           free_map_reg, free_map_next;
    logic [NS-1:0]           busy_map_reg, busy_map_next;
    logic [NS-1:0]           work_reg, work_next;
    logic                    op_reg;
    logic [cst_pkg::TAG_W-1:0] tag_reg;
    logic [SW-1:0]           slot_reg, slot_next;
    logic                    last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;
    cst_pkg::result_t        out_reg, out_next;

    logic [CW-1:0]           live;
    logic [NS-1:0]           limit;
    logic                    accept;
    logic                    cfg_wr;
    logic                    tag_wr;
    logic [cst_pkg::TAG_W-1:0] tag_rd;
    cst_pkg::find_t          ff;

    assign accept = start && (state_reg == cst_pkg::ST_IDLE);
    assign busy   = (state_reg != cst_pkg::ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cst_pkg::REG_SLOT_COUNT[2]);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cst_pkg::REG_SLOT_COUNT[2])
                    ? {{(32-CW){1'b0}}, slot_count_reg} : 32'd0;

    // saturate the count and build the search mask
    always_comb
    begin
        live = (slot_count_reg > CW'(NS)) ? CW'(NS) : slot_count_reg;
        if (live >= CW'(NS))
        begin
            limit = '1;
        end
        else
        begin
            limit = (NS'(1) << live[SW-1:0]) - NS'(1);
        end
    end

    cst_find_first u_find (
        .vec (work_reg),
        .res (ff)
    );

    assign tag_wr = (state_reg == cst_pkg::ST_SCAN) && !op_reg && ff.found;

    cst_tag_store u_tags (
        .clk     (clk),
        .wr_en   (tag_wr),
        .wr_addr (ff.index),
        .wr_data (tag_reg),
        .rd_addr (ff.index),
        .rd_data (tag_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cst_pkg::ST_SCAN;
                end
            end
            cst_pkg::ST_SCAN:
            begin
                if (op_reg && ff.found)
                begin
                    state_next = cst_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            cst_pkg::ST_EMIT:
            begin
                state_next = last_reg ? cst_pkg::ST_IDLE : cst_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        free_map_next  = free_map_reg;
        busy_map_next  = busy_map_reg;
        work_next      = work_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        unique case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                if (cmd.op)
                begin
                    work_next = cmd.d2h_seen ? (busy_map_reg & limit & ~cmd.ci_vector) : '0;
                end
                else
                begin
                    work_next = free_map_reg & limit;
                end
            end
            cst_pkg::ST_SCAN:
            begin
                if (!op_reg)
                begin
                    out_valid_next      = 1'b1;
                    out_next.last       = 1'b1;
                    if (ff.found)
                    begin
                        free_map_next[ff.index] = 1'b0;
                        busy_map_next[ff.index] = 1'b1;
                        out_next.kind       = cst_pkg::KIND_GRANT;
                        out_next.slot_index = ff.index;
                        out_next.tag_out    = tag_reg;
                        out_next.issue_bit  = NS'(1) << ff.index;
                    end
                    else
                    begin
                        out_next.kind       = cst_pkg::KIND_REFUSE;
                        out_next.slot_index = '0;
                        out_next.tag_out    = '0;
                        out_next.issue_bit  = '0;
                    end
                end
                else if (ff.found)
                begin
                    // release the slot and hold its index for the tag read
                    free_map_next[ff.index] = 1'b1;
                    busy_map_next[ff.index] = 1'b0;
                    work_next = ff.rest;
                    slot_next = ff.index;
                    last_next = !ff.more;
                end
            end
            cst_pkg::ST_EMIT:
            begin
                out_valid_next      = 1'b1;
                out_next.kind       = cst_pkg::KIND_DONE;
                out_next.slot_index = slot_reg;
                out_next.tag_out    = tag_rd;
                out_next.issue_bit  = '0;
                out_next.last       = last_reg;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cst_pkg::ST_IDLE;
            slot_count_reg <= CW'(NS);
            free_map_reg   <= '1;
            busy_map_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_map_reg  <= free_map_next;
            busy_map_reg  <= busy_map_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                slot_count_reg <= pwdata[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        slot_reg <= slot_next;
        last_reg <= last_next;
        out_reg  <= out_next;
        if (accept)
        begin
            op_reg  <= cmd.op;
            tag_reg <= cmd.request_tag;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_no_word_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result word without a command in flight");

    a_maps_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (free_map_reg & busy_map_reg) == '0)
        else $error("slot both free and busy");

    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == cst_pkg::KIND_GRANT) |-> $onehot(result.issue_bit))
        else $error("grant issue bit not one-hot");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("word follows the last word of a command");

endmodule

/* sim/command_slot_tracker_tb.sv */
// Self-checking testbench for command_slot_tracker: drives issue and completion
// commands and slot_count writes, and checks every result word against a predictor.
// Depends on cst_pkg and the command_slot_tracker RTL.
`timescale 1ns / 100ps

module command_slot_tracker_tb;

    localparam logic OP_ISSUE    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    cst_pkg::cmd_t       cmd = '0;
    logic                result_valid;
    cst_pkg::result_t    result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [cst_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Predicted slot state and register
    logic [cst_pkg::COUNT_W-1:0] cfg_slot_count = cst_pkg::COUNT_W'(32);
    logic [31:0]         slot_free = '1;
    logic [31:0]         slot_busy = '0;
    logic [cst_pkg::TAG_W-1:0] slot_tag [32];

    cst_pkg::result_t    pending_words [$];

    int errors = 0;
    int burst_left = 0;
    int n_items = 0;
    int n_grants = 0;
    int n_refusals = 0;
    int n_done = 0;
    int n_checked = 0;
    int n_settings = 0;

    command_slot_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] slot_limit(input logic [cst_pkg::COUNT_W-1:0] count);
        int n;
        n = (count > 32) ? 32 : int'(count);
        if (n >= 32)
            return '1;
        return (32'd1 << n) - 32'd1;
    endfunction

    function automatic cst_pkg::cmd_t make_word(input logic op,
                                                input logic [cst_pkg::TAG_W-1:0] tag,
                                                input logic [31:0] ci, input logic d2h);
        cst_pkg::cmd_t word;
        word.op          = op;
        word.request_tag = tag;
        word.ci_vector   = ci;
        word.d2h_seen    = d2h;
        return word;
    endfunction

    // Advance the slot maps for one accepted command and queue the words it causes
    function automatic void predict_slot_words(input cst_pkg::cmd_t word);
        logic [31:0]      limit;
        logic [31:0]      avail;
        logic [31:0]      done;
        cst_pkg::result_t w;
        limit = slot_limit(cfg_slot_count);
        if (word.op == OP_ISSUE)
        begin
            avail = slot_free & limit;
            w = '0;
            w.last = 1'b1;
            if (avail == '0)
            begin
                w.kind = cst_pkg::KIND_REFUSE;
                n_refusals++;
            end
            else
            begin
                for (int s = 31; s >= 0; s--)
                begin
                    if (avail[s])
                        w.slot_index = cst_pkg::SLOT_W'(s);
                end
                w.kind = cst_pkg::KIND_GRANT;
                w.issue_bit = 32'd1 << w.slot_index;
                w.tag_out = word.request_tag;
                slot_tag[w.slot_index] = word.request_tag;
                slot_free[w.slot_index] = 1'b0;
                slot_busy[w.slot_index] = 1'b1;
                n_grants++;
            end
            pending_words.push_back(w);
        end
        else if (word.d2h_seen)
        begin
            done = slot_busy & limit & ~word.ci_vector;
            for (int s = 0; s < 32; s++)
            begin
                if (done[s])
                begin
                    w = '0;
                    w.kind = cst_pkg::KIND_DONE;
                    w.slot_index = cst_pkg::SLOT_W'(s);
                    w.tag_out = slot_tag[s];
                    w.last = ((done >> s) >> 1) == '0;
                    slot_busy[s] = 1'b0;
                    slot_free[s] = 1'b1;
                    pending_words.push_back(w);
                    n_done++;
                end
            end
        end
    endfunction

    task automatic send_word(input cst_pkg::cmd_t word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_slot_words(word);
        burst_left--;
        n_items++;
    endtask

    // Hold the sender until every expected word is in and the block is idle
    task automatic drain_words();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0)
            @(posedge clk);
        // a completion that frees nothing still keeps the block busy briefly
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic check_slot_count_reg();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= cst_pkg::REG_SLOT_COUNT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(cfg_slot_count))
        begin
            $error("prdata: expected %0d, got %0d", cfg_slot_count, prdata);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_slot_count(input logic [cst_pkg::COUNT_W-1:0] count);
        drain_words();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= cst_pkg::REG_SLOT_COUNT;
        pwdata <= ($urandom & 32'hFFFF_FFC0) | (32'(count) & 32'h3F);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_slot_count = count;
        n_settings++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_slot_count_reg();
    endtask

    always @(posedge clk)
    begin : check_words
        cst_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: kind %0d slot %0d", result.kind,
                       result.slot_index);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                n_checked++;
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    errors++;
                end
                if (result.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           result.slot_index);
                    errors++;
                end
                if (result.tag_out !== want.tag_out)
                begin
                    $error("tag_out: expected %h, got %h", want.tag_out, result.tag_out);
                    errors++;
                end
                if (result.issue_bit !== want.issue_bit)
                begin
                    $error("issue_bit: expected %h, got %h", want.issue_bit,
                           result.issue_bit);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_and_grant();
        check_slot_count_reg();
        send_word(make_word(OP_ISSUE, 16'h0000, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(OP_ISSUE, 16'hFFFF, 32'h0000_0000, 1'b0));
        send_word(make_word(OP_COMPLETE, 16'hFFFF, 32'h0000_0000, 1'b1));
        set_slot_count(cst_pkg::COUNT_W'(3));
        repeat (4)
            send_word(make_word(OP_ISSUE, 16'($urandom), $urandom, 1'($urandom)));
    endtask

    task automatic test_completion_cases();
        // no d2h flag, then nothing cleared, then slots 0 and 2 cleared
        send_word(make_word(OP_COMPLETE, 16'hA5A5, 32'h0000_0000, 1'b0));
        send_word(make_word(OP_COMPLETE, 16'h5A5A, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(OP_COMPLETE, 16'h0001, 32'hFFFF_FFFA, 1'b1));
        send_word(make_word(OP_ISSUE, 16'h1234, 32'h0, 1'b0));
    endtask

    task automatic test_limit_changes();
        // slot 1 stays busy above the limit until the limit covers it again
        set_slot_count(cst_pkg::COUNT_W'(1));
        send_word(make_word(OP_COMPLETE, 16'h0, 32'h0, 1'b1));
        send_word(make_word(OP_ISSUE, 16'h8001, 32'h0, 1'b0));
        send_word(make_word(OP_ISSUE, 16'h8002, 32'h0, 1'b0));
        set_slot_count(cst_pkg::COUNT_W'(0));
        send_word(make_word(OP_ISSUE, 16'h7FFE, 32'h0, 1'b0));
        send_word(make_word(OP_COMPLETE, 16'h0, 32'h0, 1'b1));
        set_slot_count(cst_pkg::COUNT_W'(40));
        send_word(make_word(OP_COMPLETE, 16'h0, 32'h0, 1'b1));
        send_word(make_word(OP_ISSUE, 16'hBEEF, 32'h0, 1'b0));
    endtask

    task automatic test_random_traffic();
        logic [cst_pkg::COUNT_W-1:0] count;
        logic [31:0]        clear;
        int                 pick;
        int                 n;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: count = cst_pkg::COUNT_W'(32);
                1: count = cst_pkg::COUNT_W'(1);
                2: count = cst_pkg::COUNT_W'(63);
                3: count = cst_pkg::COUNT_W'($urandom_range(2, 31));
                4: count = cst_pkg::COUNT_W'(0);
                5: count = cst_pkg::COUNT_W'(33);
                default: count = cst_pkg::COUNT_W'($urandom_range(1, 32));
            endcase
            set_slot_count(count);
            if (count > 32)
            begin
                // fill every slot, then one refusal
                while ((slot_free & slot_limit(cfg_slot_count)) != '0)
                    send_word(make_word(OP_ISSUE, 16'($urandom), $urandom, 1'($urandom)));
                send_word(make_word(OP_ISSUE, 16'($urandom), $urandom, 1'($urandom)));
            end
            n = (count == 0) ? 12 : 32;
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_word(make_word(OP_ISSUE, 16'($urandom), $urandom, 1'($urandom)));
                else if (pick < 85)
                begin
                    case ($urandom_range(0, 3))
                        0: clear = slot_busy;
                        1: clear = $urandom & $urandom;
                        default: clear = $urandom;
                    endcase
                    send_word(make_word(OP_COMPLETE, 16'($urandom),
                                        (slot_busy & ~clear) | ($urandom & ~slot_busy),
                                        1'b1));
                end
                else
                    send_word(make_word(1'($urandom), 16'($urandom), $urandom,
                                        1'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_and_grant();
        test_completion_cases();
        test_limit_changes();
        test_random_traffic();
        drain_words();
        repeat (8) @(posedge clk);
        $display("Covered %0d commands under %0d slot_count writes, including 0 and saturation.",
                 n_items, n_settings);
        $display("Checked %0d words: %0d grants, %0d refusals, %0d completions.",
                 n_checked, n_grants, n_refusals, n_done);
        if (errors == 0 && pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* command_slot_tracker.f */
design/cst_pkg.sv
design/cst_find_first.sv
design/cst_tag_store.sv
design/command_slot_tracker.sv
sim/command_slot_tracker_tb.sv
